>>> rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> rtl/ljpf_pkg.sv
package ljpf_pkg;

   localparam int ATOM_COUNT_DEF = 1024;

   localparam logic [31:0] CUTOFF_RESET = 32'd409600;

   localparam logic [1:0] CMD_CLEAR = 2'd0;
   localparam logic [1:0] CMD_PAIR  = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;

   localparam logic [2:0] STATUS_OK     = 3'd0;
   localparam logic [2:0] STATUS_ORDER  = 3'd1;
   localparam logic [2:0] STATUS_CUTOFF = 3'd2;
   localparam logic [2:0] STATUS_ZERO   = 3'd3;
   localparam logic [2:0] STATUS_SAT    = 3'd4;

   localparam logic signed [47:0] F_MAX = 48'sh7FFF_FFFF_FFFF;
   localparam logic signed [47:0] F_MIN = 48'sh8000_0000_0000;
   localparam logic [62:0] POW_CAP  = 63'h4000_0000_0000_0000;
   localparam logic [62:0] DF_LIMIT = 63'h0200_0000_0000_0000;

   typedef struct packed {
      logic [1:0]         cmd;
      logic [9:0]         first_index;
      logic [9:0]         second_index;
      logic signed [23:0] disp_x;
      logic signed [23:0] disp_y;
      logic signed [23:0] disp_z;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic signed [47:0] force_x;
      logic signed [47:0] force_y;
      logic signed [47:0] force_z;
   } rsp_type;

   typedef struct packed {
      logic        start;
      logic [63:0] a;
      logic [63:0] b;
   } mul_req_type;

   typedef struct packed {
      logic         done;
      logic [127:0] prod;
   } mul_rsp_type;

   typedef enum logic [4:0] {
      ST_INIT,
      ST_IDLE,
      ST_CLEAR,
      ST_READ,
      ST_READ_DATA,
      ST_SQ,
      ST_SQ_WAIT,
      ST_CHECK,
      ST_DIV,
      ST_POW,
      ST_POW_WAIT,
      ST_DF,
      ST_CON,
      ST_CON_WAIT,
      ST_RD_I,
      ST_WR_I,
      ST_RD_J,
      ST_WR_J,
      ST_RSP
   } state_type;

endpackage

>>> rtl/ljpf_mul.sv
module ljpf_mul
   import ljpf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  mul_req_type mul_req,
   output mul_rsp_type mul_rsp
);

   logic [63:0]  a_ff;
   logic [63:0]  b_ff;
   logic [127:0] acc_ff;
   logic [63:0]  part_ff;
   logic [1:0]   sh_ff;
   logic [2:0]   step_ff;
   logic         busy_ff;
   logic         done_ff;

   logic [31:0]  a_half;
   logic [31:0]  b_half;
   logic [1:0]   sh_in;
   logic [63:0]  part_in;
   logic [127:0] part_shifted;

   always_comb begin
      unique case (step_ff[1:0])
         2'd0: begin
            a_half = a_ff[31:0];
            b_half = b_ff[31:0];
            sh_in  = 2'd0;
         end
         2'd1: begin
            a_half = a_ff[31:0];
            b_half = b_ff[63:32];
            sh_in  = 2'd1;
         end
         2'd2: begin
            a_half = a_ff[63:32];
            b_half = b_ff[31:0];
            sh_in  = 2'd1;
         end
         default: begin
            a_half = a_ff[63:32];
            b_half = b_ff[63:32];
            sh_in  = 2'd2;
         end
      endcase
      part_in = 64'(a_half) * 64'(b_half);
      unique case (sh_ff)
         2'd0:    part_shifted = 128'(part_ff);
         2'd1:    part_shifted = {32'b0, part_ff, 32'b0};
         default: part_shifted = {part_ff, 64'b0};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= 3'd0;
      end else begin
         done_ff <= busy_ff && (step_ff == 3'd4);
         if (mul_req.start) begin
            busy_ff <= 1'b1;
            step_ff <= 3'd0;
         end else if (busy_ff && (step_ff == 3'd4)) begin
            busy_ff <= 1'b0;
         end else if (busy_ff) begin
            step_ff <= step_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mul_req.start) begin
         a_ff   <= mul_req.a;
         b_ff   <= mul_req.b;
         acc_ff <= '0;
      end else if (busy_ff) begin
         if (step_ff != 3'd0) begin
            acc_ff <= acc_ff + part_shifted;
         end
         if (step_ff != 3'd4) begin
            part_ff <= part_in;
            sh_ff   <= sh_in;
         end
      end
   end

   assign mul_rsp.done = done_ff;
   assign mul_rsp.prod = acc_ff;

endmodule

>>> rtl/lj_pair_force_accumulate.sv
// Channel   Direction  Ports                              Content
// req       in         req_valid, req_ready, req_payload  one command
// rsp       out        rsp_valid, rsp_ready, rsp_payload  status and force
// csr       in         csr_valid, csr_ready, csr_data     squared cutoff
//
// One transaction is worked on at a time. A pair within the cutoff takes three squares and
// seven wide products on the shared multiplier and the one-bit-per-cycle divider, then
// two read-modify-write passes on the force memory. After reset the memory is zeroed
// in a pass over all ATOM_COUNT entries, during which no transaction is accepted.
// A finished result waits in the output register while the next transaction is taken.
module lj_pair_force_accumulate
   import ljpf_pkg::*;
#(
   parameter int ATOM_COUNT = ATOM_COUNT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_payload,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_payload,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_data
);

   localparam int AW = $clog2(ATOM_COUNT);

   function automatic logic [48:0] sat_add(input logic signed [47:0] a,
                                           input logic signed [47:0] b);
      logic signed [48:0] s;
      s = {a[47], a} + {b[47], b};
      if (s[48] != s[47]) begin
         return {1'b1, (s[48] ? F_MIN : F_MAX)};
      end
      return {1'b0, s[47:0]};
   endfunction

   logic [143:0] mem [ATOM_COUNT];

   state_type state_ff, state_in;
   logic [AW-1:0]  init_cnt_ff;
   logic [31:0]    cutoff_ff;
   logic [1:0]     cmd_ff;
   logic [9:0]     i_ff;
   logic [9:0]     j_ff;
   logic [23:0]    dmag_ff [3];
   logic           dneg_ff [3];
   logic [1:0]     k_ff;
   logic [47:0]    sum_ff;
   logic [31:0]    rem_ff;
   logic [5:0]     dcnt_ff;
   logic [48:0]    quo_ff;
   logic [62:0]    s2_ff;
   logic [62:0]    s3_ff;
   logic [62:0]    s4_ff;
   logic [62:0]    s7_ff;
   logic [62:0]    dfm_ff;
   logic           dfneg_ff;
   logic           sat_ff;
   logic [2:0]     status_ff;
   logic signed [47:0] con_ff [3];
   logic [143:0]   rdata_ff;
   logic           rsp_valid_ff;
   rsp_type        rsp_ff;

   mul_req_type mul_req;
   mul_rsp_type mul_rsp;

   logic           accept;
   logic           order_bad;
   logic           i_in_range;
   logic [31:0]    r2;
   logic [32:0]    trial;
   logic           trial_ge;
   logic [48:0]    quo_in;
   logic [95:0]    pow_sh;
   logic [62:0]    pow_res;
   logic [103:0]   con_sh;
   logic [47:0]    con_mag;
   logic           con_sat;
   logic signed [47:0] con_val;
   logic [62:0]    s4_clip;
   logic signed [63:0] df_val;
   logic [143:0]   upd_i;
   logic [143:0]   upd_j;
   logic           upd_i_sat;
   logic           upd_j_sat;
   logic           rsp_load;
   logic           mem_we;
   logic [AW-1:0]  mem_waddr;
   logic [143:0]   mem_wdata;
   logic           mem_re;
   logic [AW-1:0]  mem_raddr;

   ljpf_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .mul_req (mul_req),
      .mul_rsp (mul_rsp)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assign order_bad = !(req_payload.first_index < req_payload.second_index) ||
                      (32'(req_payload.second_index) >= ATOM_COUNT);
   assign i_in_range = (32'(i_ff) < ATOM_COUNT);
   assign r2 = sum_ff[47:16];

   assign trial    = {rem_ff, (dcnt_ff == 6'd48)};
   assign trial_ge = (trial >= {1'b0, r2});
   assign quo_in   = {quo_ff[47:0], trial_ge};

   assign pow_sh  = mul_rsp.prod[127:32];
   assign pow_res = (pow_sh > 96'(POW_CAP)) ? POW_CAP : pow_sh[62:0];

   assign con_sh  = mul_rsp.prod[127:24];
   assign con_sat = (con_sh > 104'(F_MAX));
   assign con_mag = con_sat ? F_MAX : con_sh[47:0];
   assign con_val = (dfneg_ff != dneg_ff[k_ff]) ? -$signed(con_mag) : $signed(con_mag);

   assign s4_clip = (s4_ff > DF_LIMIT) ? DF_LIMIT : s4_ff;
   assign df_val  = $signed(({1'b0, s7_ff} << 5) + ({1'b0, s7_ff} << 4)) -
                    $signed(({1'b0, s4_clip} << 4) + ({1'b0, s4_clip} << 3));

   always_comb begin
      logic [48:0] ri;
      logic [48:0] rj;
      upd_i_sat = 1'b0;
      upd_j_sat = 1'b0;
      upd_i = '0;
      upd_j = '0;
      for (int c = 0; c < 3; c++) begin
         ri = sat_add($signed(rdata_ff[48*c +: 48]), con_ff[c]);
         rj = sat_add($signed(rdata_ff[48*c +: 48]), -con_ff[c]);
         upd_i[48*c +: 48] = ri[47:0];
         upd_j[48*c +: 48] = rj[47:0];
         upd_i_sat = upd_i_sat | ri[48];
         upd_j_sat = upd_j_sat | rj[48];
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_INIT: begin
            if (init_cnt_ff == AW'(ATOM_COUNT - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               unique case (req_payload.cmd)
                  CMD_CLEAR: state_in = ST_CLEAR;
                  CMD_READ:  state_in = ST_READ;
                  CMD_PAIR:  state_in = order_bad ? ST_RSP : ST_SQ;
                  default:   state_in = ST_RSP;
               endcase
            end
         end
         ST_CLEAR:     state_in = ST_RSP;
         ST_READ:      state_in = ST_READ_DATA;
         ST_READ_DATA: state_in = ST_RSP;
         ST_SQ:        state_in = ST_SQ_WAIT;
         ST_SQ_WAIT: begin
            if (mul_rsp.done) state_in = (k_ff == 2'd2) ? ST_CHECK : ST_SQ;
         end
         ST_CHECK: begin
            if ((r2 > cutoff_ff) || (r2 == 32'd0)) state_in = ST_RSP;
            else state_in = ST_DIV;
         end
         ST_DIV: begin
            if (dcnt_ff == 6'd0) state_in = ST_POW;
         end
         ST_POW:       state_in = ST_POW_WAIT;
         ST_POW_WAIT: begin
            if (mul_rsp.done) state_in = (k_ff == 2'd3) ? ST_DF : ST_POW;
         end
         ST_DF:        state_in = ST_CON;
         ST_CON:       state_in = ST_CON_WAIT;
         ST_CON_WAIT: begin
            if (mul_rsp.done) state_in = (k_ff == 2'd2) ? ST_RD_I : ST_CON;
         end
         ST_RD_I:      state_in = ST_WR_I;
         ST_WR_I:      state_in = ST_RD_J;
         ST_RD_J:      state_in = ST_WR_J;
         ST_WR_J:      state_in = ST_RSP;
         ST_RSP: begin
            if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         end
         default:      state_in = ST_INIT;
      endcase
   end

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = AW'(i_ff);
      mem_wdata = '0;
      mem_re    = 1'b0;
      mem_raddr = AW'(i_ff);
      mul_req   = '0;
      rsp_load  = 1'b0;
      unique case (state_ff)
         ST_INIT: begin
            mem_we    = 1'b1;
            mem_waddr = init_cnt_ff;
         end
         ST_CLEAR: begin
            mem_we = i_in_range;
         end
         ST_READ: begin
            mem_re = i_in_range;
         end
         ST_SQ: begin
            mul_req.start = 1'b1;
            mul_req.a     = 64'(dmag_ff[k_ff]);
            mul_req.b     = 64'(dmag_ff[k_ff]);
         end
         ST_POW: begin
            mul_req.start = 1'b1;
            unique case (k_ff)
               2'd0: begin
                  mul_req.a = 64'(quo_ff);
                  mul_req.b = 64'(quo_ff);
               end
               2'd1: begin
                  mul_req.a = 64'(s2_ff);
                  mul_req.b = 64'(quo_ff);
               end
               2'd2: begin
                  mul_req.a = 64'(s2_ff);
                  mul_req.b = 64'(s2_ff);
               end
               default: begin
                  mul_req.a = 64'(s4_ff);
                  mul_req.b = 64'(s3_ff);
               end
            endcase
         end
         ST_CON: begin
            mul_req.start = 1'b1;
            mul_req.a     = 64'(dfm_ff);
            mul_req.b     = 64'(dmag_ff[k_ff]);
         end
         ST_RD_I: begin
            mem_re = 1'b1;
         end
         ST_WR_I: begin
            mem_we    = 1'b1;
            mem_wdata = upd_i;
         end
         ST_RD_J: begin
            mem_re    = 1'b1;
            mem_raddr = AW'(j_ff);
         end
         ST_WR_J: begin
            mem_we    = 1'b1;
            mem_waddr = AW'(j_ff);
            mem_wdata = upd_j;
         end
         ST_RSP: begin
            rsp_load = !rsp_valid_ff || rsp_ready;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      if (mem_re) rdata_ff <= mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         init_cnt_ff  <= '0;
         cutoff_ff    <= CUTOFF_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_INIT) init_cnt_ff <= init_cnt_ff + AW'(1);
         if (csr_valid && csr_ready) cutoff_ff <= csr_data;
         if (rsp_load) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ff.status  <= status_ff;
         rsp_ff.force_x <= con_ff[0];
         rsp_ff.force_y <= con_ff[1];
         rsp_ff.force_z <= con_ff[2];
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd_ff     <= req_payload.cmd;
               i_ff       <= req_payload.first_index;
               j_ff       <= req_payload.second_index;
               dneg_ff[0] <= req_payload.disp_x[23];
               dneg_ff[1] <= req_payload.disp_y[23];
               dneg_ff[2] <= req_payload.disp_z[23];
               dmag_ff[0] <= req_payload.disp_x[23] ? -req_payload.disp_x
                                                    : req_payload.disp_x;
               dmag_ff[1] <= req_payload.disp_y[23] ? -req_payload.disp_y
                                                    : req_payload.disp_y;
               dmag_ff[2] <= req_payload.disp_z[23] ? -req_payload.disp_z
                                                    : req_payload.disp_z;
               k_ff       <= 2'd0;
               sum_ff     <= '0;
               sat_ff     <= 1'b0;
               status_ff  <= ((req_payload.cmd == CMD_PAIR) && order_bad) ? STATUS_ORDER
                                                                          : STATUS_OK;
               for (int c = 0; c < 3; c++) con_ff[c] <= '0;
            end
         end
         ST_READ_DATA: begin
            if (i_in_range && (cmd_ff == CMD_READ)) begin
               for (int c = 0; c < 3; c++) con_ff[c] <= $signed(rdata_ff[48*c +: 48]);
            end
         end
         ST_SQ_WAIT: begin
            if (mul_rsp.done) begin
               sum_ff <= sum_ff + mul_rsp.prod[47:0];
               k_ff   <= k_ff + 2'd1;
            end
         end
         ST_CHECK: begin
            if (r2 > cutoff_ff) status_ff <= STATUS_CUTOFF;
            else if (r2 == 32'd0) status_ff <= STATUS_ZERO;
            rem_ff  <= '0;
            quo_ff  <= '0;
            dcnt_ff <= 6'd48;
            k_ff    <= 2'd0;
         end
         ST_DIV: begin
            rem_ff  <= trial_ge ? 32'(trial - {1'b0, r2}) : trial[31:0];
            quo_ff  <= quo_in;
            dcnt_ff <= dcnt_ff - 6'd1;
         end
         ST_POW_WAIT: begin
            if (mul_rsp.done) begin
               unique case (k_ff)
                  2'd0:    s2_ff <= pow_res;
                  2'd1:    s3_ff <= pow_res;
                  2'd2:    s4_ff <= pow_res;
                  default: s7_ff <= pow_res;
               endcase
               k_ff <= k_ff + 2'd1;
            end
         end
         ST_DF: begin
            k_ff <= 2'd0;
            if (s7_ff > DF_LIMIT) begin
               dfm_ff   <= POW_CAP;
               dfneg_ff <= 1'b0;
               sat_ff   <= 1'b1;
            end else begin
               dfm_ff   <= df_val[63] ? 63'(-df_val) : df_val[62:0];
               dfneg_ff <= df_val[63];
            end
         end
         ST_CON_WAIT: begin
            if (mul_rsp.done) begin
               con_ff[k_ff] <= con_val;
               sat_ff       <= sat_ff | con_sat;
               k_ff         <= k_ff + 2'd1;
            end
         end
         ST_WR_I: begin
            sat_ff <= sat_ff | upd_i_sat;
         end
         ST_WR_J: begin
            status_ff <= (sat_ff || upd_j_sat) ? STATUS_SAT : STATUS_OK;
         end
         default: begin
         end
      endcase
   end

endmodule

>>> rtl/ljpf_check.sv
`include "assert_macros.svh"

module ljpf_check
   import ljpf_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input req_type     req_payload,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input rsp_type     rsp_payload,
   input logic        csr_valid,
   input logic        csr_ready,
   input logic [31:0] csr_data
);

   // A stalled result transaction keeps its payload.
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload))

   // Only one transaction is in work at a time.
   `ASSERT_NEXT(a_one_at_a_time, clock, reset, req_valid && req_ready, !req_ready)

   `ASSERT_SAME(a_status_range, clock, reset, rsp_valid, rsp_payload.status <= STATUS_SAT)

   // Skipped pairs carry no force.
   `ASSERT_SAME(a_skip_zero, clock, reset, rsp_valid && (rsp_payload.status == STATUS_ORDER || rsp_payload.status == STATUS_CUTOFF || rsp_payload.status == STATUS_ZERO), rsp_payload.force_x == 48'sd0 && rsp_payload.force_y == 48'sd0 && rsp_payload.force_z == 48'sd0)

endmodule

bind lj_pair_force_accumulate ljpf_check u_ljpf_check (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload),
   .csr_valid   (csr_valid),
   .csr_ready   (csr_ready),
   .csr_data    (csr_data)
);
